// File: src/utf8_stream_decoder_macros.svh
// Assertion macros used by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define USD_ASSERT_SAME(label, clk, rst_n, cond, check) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error("usd assertion failed");

`define USD_ASSERT_NEXT(label, clk, rst_n, cond, check) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error("usd assertion failed");

`else

`define USD_ASSERT_SAME(label, clk, rst_n, cond, check)

`define USD_ASSERT_NEXT(label, clk, rst_n, cond, check)

`endif

`endif

// File: src/usd_pkg.sv
// Types, constants and lookup functions of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package usd_pkg;

    localparam int unsigned CpWidth = 32;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_TRUNC = 2'd2
    } usd_kind_t;

    typedef struct packed {
        logic                valid;
        logic [CpWidth-1:0]  code_point;
        usd_kind_t           kind;
    } usd_result_t;

    localparam logic [CpWidth-1:0] TRUNC_CODE = 32'hFFFF_FFFF;

    // Number of continuation words announced by a lead word.
    function automatic logic [2:0] trailing_count(input logic [7:0] b);
        logic [2:0] n;
        if (b < 8'hC0) begin
            n = 3'd0;
        end else if (b < 8'hE0) begin
            n = 3'd1;
        end else if (b < 8'hF0) begin
            n = 3'd2;
        end else if (b < 8'hF8) begin
            n = 3'd3;
        end else if (b < 8'hFC) begin
            n = 3'd4;
        end else begin
            n = 3'd5;
        end
        return n;
    endfunction

    // Offset removed from the accumulated sum for each sequence length.
    function automatic logic [CpWidth-1:0] seq_offset(input logic [2:0] n);
        logic [CpWidth-1:0] off;
        unique case (n)
            3'd1:    off = 32'h0000_3080;
            3'd2:    off = 32'h000E_2080;
            3'd3:    off = 32'h03C8_2080;
            3'd4:    off = 32'hFA08_2080;
            3'd5:    off = 32'h8208_2080;
            default: off = 32'h0000_0000;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// File: src/utf8_stream_decoder.sv
// UTF-8 stream decoder: a word per cycle unless stalled; returns code points.
//
// The byte channel (byte_valid, byte_ready, data_byte) takes one word of a
// NUL-terminated UTF-8 string per handshake. The result channel (result_valid,
// result_ready, code_point, kind) gives at most one result per word: a
// character, an end of string, or a truncated sequence that also ends it.
// Lead words and inner continuation words of a multiword sequence give no
// result; the last continuation word gives the code point.
// A word accepted into the input register is decoded into the result
// register once that register can take it, and its result is then offered.
// The block takes one word every cycle while the receiver does not stall;
// the limit is the single decode step between the input and result registers.
// When the receiver stalls, the result register holds its word and the
// input register keeps accepting until it is full, so at most two words are
// in flight; byte_ready then follows result_ready.
// Reset empties both registers and leaves the decoder waiting for a lead
// word with a cleared accumulator.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder
    import usd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    output logic               byte_ready,
    input  wire logic [7:0]    data_byte,
    output logic               result_valid,
    input  wire logic          result_ready,
    output logic [CpWidth-1:0] code_point,
    output logic [1:0]         kind
);

    logic        stage_valid;
    logic [7:0]  stage_byte;
    logic        advance;
    logic        can_take;
    usd_result_t result;

    assign advance = stage_valid && can_take;

    usd_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .data_byte   (data_byte),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    usd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .stage_byte (stage_byte),
        .result     (result)
    );

    usd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && result.valid),
        .result       (result),
        .can_take     (can_take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .code_point   (code_point),
        .kind         (kind)
    );

endmodule

`default_nettype wire

// File: src/usd_in_stage.sv
// Input register that holds one incoming word until the decoder takes it.
`timescale 1ns / 1ps
`default_nettype none

module usd_in_stage
    import usd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       advance,
    output logic            stage_valid,
    output logic [7:0]      stage_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign byte_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_valid && byte_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            byte_reg <= data_byte;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

endmodule

`default_nettype wire

// File: src/usd_decode.sv
// Sequence state and the combinational decode step for one word.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module usd_decode
    import usd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] stage_byte,
    output usd_result_t     result
);

    logic [2:0]         bytes_left_reg;
    logic [2:0]         bytes_left_next;
    logic [2:0]         seq_trailing_reg;
    logic [2:0]         seq_trailing_next;
    logic [CpWidth-1:0] acc_reg;
    logic [CpWidth-1:0] acc_next;
    logic [2:0]         lead_count;
    logic [CpWidth-1:0] acc_sum;

    assign lead_count = trailing_count(stage_byte);
    assign acc_sum    = acc_reg + {{(CpWidth-8){1'b0}}, stage_byte};

    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        seq_trailing_next = seq_trailing_reg;
        acc_next          = acc_reg;
        result.valid      = 1'b0;
        result.code_point = '0;
        result.kind       = KIND_CHAR;
        if (bytes_left_reg == 3'd0)
        begin
            if (stage_byte == 8'd0)
            begin
                bytes_left_next   = 3'd0;
                seq_trailing_next = 3'd0;
                acc_next          = '0;
                result.valid      = 1'b1;
                result.kind       = KIND_END;
            end
            else if (lead_count == 3'd0)
            begin
                result.valid      = 1'b1;
                result.code_point = {{(CpWidth-8){1'b0}}, stage_byte};
            end
            else
            begin
                acc_next          = {{(CpWidth-14){1'b0}}, stage_byte, 6'd0};
                bytes_left_next   = lead_count;
                seq_trailing_next = lead_count;
            end
        end
        else if (stage_byte == 8'd0)
        begin
            bytes_left_next   = 3'd0;
            seq_trailing_next = 3'd0;
            acc_next          = '0;
            result.valid      = 1'b1;
            result.code_point = TRUNC_CODE;
            result.kind       = KIND_TRUNC;
        end
        else if (bytes_left_reg == 3'd1)
        begin
            bytes_left_next   = 3'd0;
            seq_trailing_next = 3'd0;
            acc_next          = '0;
            result.valid      = 1'b1;
            result.code_point = acc_sum - seq_offset(seq_trailing_reg);
        end
        else
        begin
            acc_next        = {acc_sum[CpWidth-7:0], 6'd0};
            bytes_left_next = bytes_left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg   <= 3'd0;
            seq_trailing_reg <= 3'd0;
            acc_reg          <= '0;
        end
        else if (step)
        begin
            bytes_left_reg   <= bytes_left_next;
            seq_trailing_reg <= seq_trailing_next;
            acc_reg          <= acc_next;
        end
    end

    // A sequence never announces more than five continuation words.
    `USD_ASSERT_SAME(a_left_range, clk, rst_n, 1'b1, bytes_left_reg <= 3'd5)
    // The words still expected never exceed the length of the sequence.
    `USD_ASSERT_SAME(a_left_within_seq, clk, rst_n, bytes_left_reg != 3'd0,
        seq_trailing_reg >= bytes_left_reg && seq_trailing_reg != 3'd0)
    // A truncation can only be reported inside a sequence.
    `USD_ASSERT_SAME(a_trunc_in_seq, clk, rst_n, result.valid && result.kind == KIND_TRUNC,
        bytes_left_reg != 3'd0)
    // Every end or truncation leaves the decoder waiting for a lead word.
    `USD_ASSERT_NEXT(a_end_clears, clk, rst_n,
        step && result.valid && result.kind != KIND_CHAR,
        bytes_left_reg == 3'd0 && acc_reg == '0)

endmodule

`default_nettype wire

// File: src/usd_out_stage.sv
// Result register that holds a decoded word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module usd_out_stage
    import usd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire usd_result_t   result,
    output logic               can_take,
    output logic               result_valid,
    input  wire logic          result_ready,
    output logic [CpWidth-1:0] code_point,
    output logic [1:0]         kind
);

    logic               valid_reg;
    logic               valid_next;
    logic [CpWidth-1:0] code_point_reg;
    usd_kind_t          kind_reg;

    assign can_take = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_point_reg <= result.code_point;
            kind_reg       <= result.kind;
        end
    end

    assign result_valid = valid_reg;
    assign code_point   = code_point_reg;
    assign kind         = kind_reg;

endmodule

`default_nettype wire
